// ----- hw/rtl/mvat_pkg.sv -----
// mvat_pkg: shared types, widths and register codes of the mesh vertex transform
// used by every module under hw/rtl
`default_nettype none

package mvat_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int NUM_REGS = 6;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_LIMIT = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_CENTER = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCALE  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW0   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW1   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW2   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET = 3'd5;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_NORMAL = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic signed [COORD_WIDTH-1:0] in_x;
    logic signed [COORD_WIDTH-1:0] in_y;
    logic signed [COORD_WIDTH-1:0] in_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic                          saturated;
  } result_t;

  function automatic int cfg_data_width(int coef_w);
    return (3 * coef_w > 3 * COORD_WIDTH) ? 3 * coef_w : 3 * COORD_WIDTH;
  endfunction

  function automatic int cfg_reg_bits(int coef_w);
    return (cfg_data_width(coef_w) > REG_LIMIT) ? REG_LIMIT : cfg_data_width(coef_w);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mvat_cfg.sv -----
// mvat_cfg: configuration register file and unpacking of the packed components
// depends on mvat_pkg
`default_nettype none

module mvat_cfg
  import mvat_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]                  cfg_index,
  input  wire logic [cfg_data_width(COEF_WIDTH)-1:0]  cfg_data,
  output logic signed [COORD_WIDTH-1:0]               center [3],
  output logic signed [COEF_WIDTH-1:0]                scale [3],
  output logic signed [COEF_WIDTH-1:0]                rot [3][3],
  output logic signed [COORD_WIDTH-1:0]               offset [3]
);

  localparam int RB = cfg_reg_bits(COEF_WIDTH);
  localparam int CW3 = 3 * COORD_WIDTH;
  localparam int FW3 = 3 * COEF_WIDTH;

  logic [RB-1:0] regs [NUM_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) regs[k] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER: regs[REG_CENTER] <= cfg_data[RB-1:0];
        REG_SCALE:  regs[REG_SCALE]  <= cfg_data[RB-1:0];
        REG_ROW0:   regs[REG_ROW0]   <= cfg_data[RB-1:0];
        REG_ROW1:   regs[REG_ROW1]   <= cfg_data[RB-1:0];
        REG_ROW2:   regs[REG_ROW2]   <= cfg_data[RB-1:0];
        REG_OFFSET: regs[REG_OFFSET] <= cfg_data[RB-1:0];
        default: ;
      endcase
    end
  end

  // bits beyond the stored width read as zero
  logic [CW3-1:0] cen_ext, off_ext;
  logic [FW3-1:0] scl_ext, row0_ext, row1_ext, row2_ext;

  always_comb begin
    cen_ext  = CW3'(regs[REG_CENTER]);
    off_ext  = CW3'(regs[REG_OFFSET]);
    scl_ext  = FW3'(regs[REG_SCALE]);
    row0_ext = FW3'(regs[REG_ROW0]);
    row1_ext = FW3'(regs[REG_ROW1]);
    row2_ext = FW3'(regs[REG_ROW2]);
    for (int i = 0; i < 3; i++) begin
      center[i] = cen_ext[i*COORD_WIDTH +: COORD_WIDTH];
      offset[i] = off_ext[i*COORD_WIDTH +: COORD_WIDTH];
      scale[i]  = scl_ext[i*COEF_WIDTH +: COEF_WIDTH];
      rot[0][i] = row0_ext[i*COEF_WIDTH +: COEF_WIDTH];
      rot[1][i] = row1_ext[i*COEF_WIDTH +: COEF_WIDTH];
      rot[2][i] = row2_ext[i*COEF_WIDTH +: COEF_WIDTH];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mvat_scale.sv -----
// mvat_scale: centre subtraction stage and per-axis scale stage with rounding
// depends on mvat_pkg
`default_nettype none

module mvat_scale
  import mvat_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     up_valid,
  output logic                                          up_ready,
  input  wire point_t                                   pt,
  input  wire logic signed [COORD_WIDTH-1:0]            center [3],
  input  wire logic signed [COEF_WIDTH-1:0]             scale [3],
  output logic                                          down_valid,
  input  wire logic                                     down_ready,
  output logic                                          down_kind,
  output logic signed [COORD_WIDTH+6-1:0]               down_s [3]
);

  localparam int SF = COEF_WIDTH - 4;
  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = DW + COEF_WIDTH;
  localparam int SW = MW + 1 - SF;
  localparam logic signed [MW:0] HALF = (MW+1)'(1) <<< (SF - 1);

  logic                 a_v, a_kind;
  logic signed [DW-1:0] a_d [3];
  logic                 b_v, b_kind;
  logic signed [SW-1:0] b_s [3];
  logic                 a_adv, b_adv;
  logic signed [COORD_WIDTH-1:0] coord [3];
  logic signed [MW-1:0] prod [3];
  logic signed [MW:0]   rnd [3];
  logic signed [MW:0]   shf [3];

  assign b_adv    = !b_v || down_ready;
  assign a_adv    = !a_v || b_adv;
  assign up_ready = a_adv;

  always_comb begin
    coord[0] = pt.in_x;
    coord[1] = pt.in_y;
    coord[2] = pt.in_z;
    for (int i = 0; i < 3; i++) begin
      prod[i] = MW'(a_d[i]) * MW'(scale[i]);
      rnd[i]  = (MW+1)'(prod[i]) + HALF;
      shf[i]  = rnd[i] >>> SF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      if (a_adv) a_v <= up_valid;
      if (b_adv) b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && up_valid) begin
      a_kind <= pt.kind;
      for (int i = 0; i < 3; i++) begin
        if (pt.kind == KIND_VERTEX) a_d[i] <= DW'(coord[i]) - DW'(center[i]);
        else                        a_d[i] <= DW'(coord[i]);
      end
    end
    if (b_adv && a_v) begin
      b_kind <= a_kind;
      for (int i = 0; i < 3; i++) b_s[i] <= shf[i][SW-1:0];
    end
  end

  assign down_valid = b_v;
  assign down_kind  = b_kind;
  always_comb begin
    for (int i = 0; i < 3; i++) down_s[i] = b_s[i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mvat_rotate.sv -----
// mvat_rotate: matrix product stage and row sum stage with rounding
// depends on mvat_pkg
`default_nettype none

module mvat_rotate
  import mvat_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  up_valid,
  output logic                                       up_ready,
  input  wire logic                                  up_kind,
  input  wire logic signed [COORD_WIDTH+6-1:0]       up_s [3],
  input  wire logic signed [COEF_WIDTH-1:0]          rot [3][3],
  output logic                                       down_valid,
  input  wire logic                                  down_ready,
  output logic                                       down_kind,
  output logic signed [COORD_WIDTH+6+3-1:0]          down_r [3]
);

  localparam int RF = COEF_WIDTH - 2;
  localparam int SW = COORD_WIDTH + 6;
  localparam int PW = COEF_WIDTH + SW;
  localparam int AW = PW + 3;
  localparam int RW = SW + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (RF - 1);

  logic                 c_v, c_kind;
  logic signed [PW-1:0] c_p [3][3];
  logic                 d_v, d_kind;
  logic signed [RW-1:0] d_r [3];
  logic                 c_adv, d_adv;
  logic signed [AW-1:0] acc [3];
  logic signed [AW-1:0] shf [3];

  assign d_adv    = !d_v || down_ready;
  assign c_adv    = !c_v || d_adv;
  assign up_ready = c_adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(c_p[i][0]) + AW'(c_p[i][1]) + AW'(c_p[i][2]) + HALF;
      shf[i] = acc[i] >>> RF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
      d_v <= 1'b0;
    end else begin
      if (c_adv) c_v <= up_valid;
      if (d_adv) d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv && up_valid) begin
      c_kind <= up_kind;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) c_p[i][j] <= PW'(rot[i][j]) * PW'(up_s[j]);
      end
    end
    if (d_adv && c_v) begin
      d_kind <= c_kind;
      for (int i = 0; i < 3; i++) d_r[i] <= shf[i][RW-1:0];
    end
  end

  assign down_valid = d_v;
  assign down_kind  = d_kind;
  always_comb begin
    for (int i = 0; i < 3; i++) down_r[i] = d_r[i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mvat_place.sv -----
// mvat_place: offset add, saturation and the output register
// depends on mvat_pkg
`default_nettype none

module mvat_place
  import mvat_pkg::*;
(
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               up_valid,
  output logic                                    up_ready,
  input  wire logic                               up_kind,
  input  wire logic signed [COORD_WIDTH+6+3-1:0]  up_r [3],
  input  wire logic signed [COORD_WIDTH-1:0]      offset [3],
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output result_t                                 res
);

  localparam int RW = COORD_WIDTH + 6 + 3;
  localparam int TW = RW + 1;
  localparam logic signed [TW-1:0] HI = TW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic signed [TW-1:0] LO = -HI - TW'(1);

  logic                          e_v;
  result_t                       e_res;
  logic signed [TW-1:0]          t [3];
  logic signed [COORD_WIDTH-1:0] c [3];
  logic [2:0]                    clip;
  logic                          e_adv;

  assign e_adv    = !e_v || res_ready;
  assign up_ready = e_adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (up_kind == KIND_VERTEX) t[i] = TW'(up_r[i]) + TW'(offset[i]);
      else                        t[i] = TW'(up_r[i]);
      if (t[i] > HI) begin
        c[i]    = HI[COORD_WIDTH-1:0];
        clip[i] = 1'b1;
      end else if (t[i] < LO) begin
        c[i]    = LO[COORD_WIDTH-1:0];
        clip[i] = 1'b1;
      end else begin
        c[i]    = t[i][COORD_WIDTH-1:0];
        clip[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (e_adv) begin
      e_v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_adv && up_valid) begin
      e_res.out_x     <= c[0];
      e_res.out_y     <= c[1];
      e_res.out_z     <= c[2];
      e_res.saturated <= |clip;
    end
  end

  assign res_valid = e_v;
  assign res       = e_res;

endmodule

`default_nettype wire

// ----- hw/rtl/mesh_vertex_affine_transform.sv -----
// mesh_vertex_affine_transform: top level of the mesh point transform
// depends on mvat_pkg, mvat_cfg, mvat_scale, mvat_rotate, mvat_place
//
// Each item on the pt channel is one point: a vertex (kind 0) that gets
// centre subtraction, per-axis scale, 3x3 rotation and offset, or a normal
// (kind 1) that gets scale and rotation only. The res channel returns one
// item per point, in order, each component saturated to Q12.8 with a flag.
// The cfg port writes the six transform registers by index; writes to an
// unknown index are dropped. Write them only while no item is in flight.
// Five register stages: subtract, scale multiply, rotate multiply, row sum,
// offset and clamp. One item can be taken every cycle unless a stall on
// res_ready has backed up to pt_ready.
// Each stage holds its item while the stage behind it is full; a stall on
// res_ready fills bubbles first and then backs up to pt_ready, nothing is
// dropped or repeated.
// Synchronous reset empties the pipeline and clears the six transform registers to zero.
`default_nettype none

module mesh_vertex_affine_transform
  import mvat_pkg::*;
#(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   pt_valid,
  output logic                                        pt_ready,
  input  wire point_t                                 pt,
  output logic                                        res_valid,
  input  wire logic                                   res_ready,
  output result_t                                     res,
  input  wire logic                                   cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]                  cfg_index,
  input  wire logic [cfg_data_width(COEF_WIDTH)-1:0]  cfg_data
);

  localparam int SW = COORD_WIDTH + 6;
  localparam int RW = SW + 3;

  logic signed [COORD_WIDTH-1:0] center [3];
  logic signed [COORD_WIDTH-1:0] offset [3];
  logic signed [COEF_WIDTH-1:0]  scale [3];
  logic signed [COEF_WIDTH-1:0]  rot [3][3];

  logic                 s_valid, s_ready, s_kind;
  logic signed [SW-1:0] s_val [3];
  logic                 r_valid, r_ready, r_kind;
  logic signed [RW-1:0] r_val [3];

  mvat_cfg #(.COEF_WIDTH(COEF_WIDTH)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .center    (center),
    .scale     (scale),
    .rot       (rot),
    .offset    (offset)
  );

  mvat_scale #(.COEF_WIDTH(COEF_WIDTH)) u_scale (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (pt_valid),
    .up_ready   (pt_ready),
    .pt         (pt),
    .center     (center),
    .scale      (scale),
    .down_valid (s_valid),
    .down_ready (s_ready),
    .down_kind  (s_kind),
    .down_s     (s_val)
  );

  mvat_rotate #(.COEF_WIDTH(COEF_WIDTH)) u_rotate (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s_valid),
    .up_ready   (s_ready),
    .up_kind    (s_kind),
    .up_s       (s_val),
    .rot        (rot),
    .down_valid (r_valid),
    .down_ready (r_ready),
    .down_kind  (r_kind),
    .down_r     (r_val)
  );

  mvat_place u_place (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (r_valid),
    .up_ready  (r_ready),
    .up_kind   (r_kind),
    .up_r      (r_val),
    .offset    (offset),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire

// ----- dv/mvat_check_pkg.sv -----
// mvat_check_pkg: self-contained prediction of the mesh point transform and an
// in-order result checker for the testbench, depends on mvat_pkg only
`timescale 1ns / 1ps

package mvat_check_pkg;
  import mvat_pkg::*;

  localparam int COEF_BITS   = COEF_WIDTH_DEF;
  localparam int SCALE_SHIFT = COEF_BITS - 4;
  localparam int ROT_SHIFT   = COEF_BITS - 2;
  localparam int CFG_BITS    = cfg_data_width(COEF_BITS);

  typedef logic [CFG_BITS-1:0] cfg_word_t;

  class vertex_xform_checker;
    cfg_word_t   xform_regs [NUM_REGS];
    result_t     due_results [$];
    int unsigned errors;

    function new();
      foreach (xform_regs[i]) xform_regs[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, cfg_word_t data);
      if (idx < NUM_REGS) xform_regs[idx] = data;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // signed component i of width w, zero when it lies beyond bit 63
    function longint field(int r, int i, int w);
      bit [63:0] v;
      if (i * w >= 64) return 0;
      v = 64'(xform_regs[r]) >> (i * w);
      return longint'($signed(v << (64 - w))) >>> (64 - w);
    endfunction

    // round to nearest, ties toward plus infinity
    function longint round_shr(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function void take_point(point_t p);
      longint pin [3];
      longint scaled [3];
      longint acc;
      longint r;
      longint hi;
      longint lo;
      logic [COORD_WIDTH-1:0] o [3];
      bit sat;
      result_t want;
      hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
      lo = -hi - 1;
      pin[0] = p.in_x;
      pin[1] = p.in_y;
      pin[2] = p.in_z;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (p.kind == KIND_VERTEX) pin[i] -= field(int'(REG_CENTER), i, COORD_WIDTH);
        scaled[i] = round_shr(pin[i] * field(int'(REG_SCALE), i, COEF_BITS), SCALE_SHIFT);
      end
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) begin
          acc += field(int'(REG_ROW0) + i, j, COEF_BITS) * scaled[j];
        end
        r = round_shr(acc, ROT_SHIFT);
        if (p.kind == KIND_VERTEX) r += field(int'(REG_OFFSET), i, COORD_WIDTH);
        if (r > hi) begin
          r = hi;
          sat = 1'b1;
        end else if (r < lo) begin
          r = lo;
          sat = 1'b1;
        end
        o[i] = r[COORD_WIDTH-1:0];
      end
      want.out_x = o[0];
      want.out_y = o[1];
      want.out_z = o[2];
      want.saturated = sat;
      due_results.push_back(want);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d z=%0d sat=%0b",
                         got.out_x, got.out_y, got.out_z, got.saturated));
        return;
      end
      want = due_results.pop_front();
      if (got.out_x !== want.out_x || got.out_y !== want.out_y ||
          got.out_z !== want.out_z || got.saturated !== want.saturated) begin
        report($sformatf("result mismatch: expected x=%0d y=%0d z=%0d sat=%0b, got %s",
                         want.out_x, want.out_y, want.out_z, want.saturated,
                         $sformatf("x=%0d y=%0d z=%0d sat=%0b",
                                   got.out_x, got.out_y, got.out_z, got.saturated)));
      end
    endfunction
  endclass

endpackage

// ----- dv/tb_mesh_vertex_affine_transform.sv -----
// tb_mesh_vertex_affine_transform: drives points and register settings into the
// mesh point transform with random idling and checks every result in order
// depends on mvat_pkg, mvat_check_pkg and the rtl of mesh_vertex_affine_transform
`timescale 1ns / 1ps

module tb_mesh_vertex_affine_transform;
  import mvat_pkg::*;
  import mvat_check_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = CFG_ADDR_W'(NUM_REGS);
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = '1;

  localparam int COORD_HI   = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int COORD_LO   = -COORD_HI - 1;
  localparam int COEF_HI    = (1 << (COEF_BITS - 1)) - 1;
  localparam int COEF_LO    = -COEF_HI - 1;
  localparam int UNIT_SCALE = 1 << SCALE_SHIFT;
  localparam int UNIT_ROT   = 1 << ROT_SHIFT;

  localparam int RANDOM_PHASES    = 10;
  localparam int POINTS_PER_PHASE = 180;
  localparam int HOLD_AFTER       = 600;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 20;

  typedef enum {CFG_ZERO, CFG_IDENTITY, CFG_TOP, CFG_BOTTOM, CFG_NOISE,
                CFG_ROTATION} cfg_style_t;

  cfg_style_t phase_plan [RANDOM_PHASES] = '{CFG_NOISE, CFG_ROTATION, CFG_IDENTITY, CFG_TOP,
                                             CFG_ROTATION, CFG_BOTTOM, CFG_NOISE, CFG_ZERO,
                                             CFG_ROTATION, CFG_NOISE};

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      pt_valid  = 1'b0;
  point_t    pt        = '0;
  logic      res_ready = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_index = '0;
  cfg_word_t cfg_data  = '0;
  logic      pt_ready;
  logic      res_valid;
  result_t   res;

  vertex_xform_checker chk;
  int send_gap_max   = 9;
  int take_stall_max = 9;
  int results_taken;
  bit hold_done;

  mesh_vertex_affine_transform dut (
    .clk       (clk),
    .rst       (rst),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .pt        (pt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic cfg_word_t random_word();
    return cfg_word_t'({$urandom(), $urandom()});
  endfunction

  function automatic cfg_word_t pack_coord(int a, int b, int c);
    return cfg_word_t'({c[COORD_WIDTH-1:0], b[COORD_WIDTH-1:0], a[COORD_WIDTH-1:0]});
  endfunction

  // bits above the three coefficients carry junk that must be ignored
  function automatic cfg_word_t pack_coef(int a, int b, int c);
    return cfg_word_t'({c[COEF_BITS-1:0], b[COEF_BITS-1:0], a[COEF_BITS-1:0]}) |
           (cfg_word_t'($urandom()) << (3 * COEF_BITS));
  endfunction

  function automatic point_t make_point(logic kind, int x, int y, int z);
    point_t p;
    p.kind = kind;
    p.in_x = x[COORD_WIDTH-1:0];
    p.in_y = y[COORD_WIDTH-1:0];
    p.in_z = z[COORD_WIDTH-1:0];
    return p;
  endfunction

  function automatic int random_coord();
    case ($urandom_range(0, 5))
      0, 1, 2: return int'($urandom());
      3, 4:    return spread(4096);
      default: begin
        case ($urandom_range(0, 3))
          0:       return COORD_HI;
          1:       return COORD_LO;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  function automatic point_t random_point();
    return make_point(logic'($urandom_range(0, 1)), random_coord(), random_coord(),
                      random_coord());
  endfunction

  task automatic drain();
    pt_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] idx, cfg_word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    chk.write_reg(idx, data);
  endtask

  task automatic load_regs(cfg_word_t center, cfg_word_t scale, cfg_word_t row0,
                           cfg_word_t row1, cfg_word_t row2, cfg_word_t offset);
    drain();
    write_cfg(REG_CENTER, center);
    write_cfg(REG_SPARE_LO, random_word());
    write_cfg(REG_SCALE, scale);
    write_cfg(REG_ROW0, row0);
    write_cfg(REG_ROW1, row1);
    write_cfg(REG_SPARE_HI, random_word());
    write_cfg(REG_ROW2, row2);
    write_cfg(REG_OFFSET, offset);
    cfg_we <= 1'b0;
  endtask

  task automatic program_style(cfg_style_t style);
    case (style)
      CFG_ZERO: load_regs('0, '0, '0, '0, '0, '0);
      CFG_IDENTITY: load_regs(pack_coord(spread(5000), spread(5000), spread(5000)),
                              pack_coef(UNIT_SCALE, UNIT_SCALE, UNIT_SCALE),
                              pack_coef(UNIT_ROT, 0, 0), pack_coef(0, UNIT_ROT, 0),
                              pack_coef(0, 0, UNIT_ROT),
                              pack_coord(spread(5000), spread(5000), spread(5000)));
      CFG_TOP: load_regs(pack_coord(COORD_HI, COORD_HI, COORD_HI),
                         pack_coef(COEF_HI, COEF_HI, COEF_HI),
                         pack_coef(COEF_HI, COEF_HI, COEF_HI),
                         pack_coef(COEF_HI, COEF_HI, COEF_HI),
                         pack_coef(COEF_HI, COEF_HI, COEF_HI),
                         pack_coord(COORD_HI, COORD_HI, COORD_HI));
      CFG_BOTTOM: load_regs(pack_coord(COORD_LO, COORD_LO, COORD_LO),
                            pack_coef(COEF_LO, COEF_LO, COEF_LO),
                            pack_coef(COEF_LO, COEF_LO, COEF_LO),
                            pack_coef(COEF_LO, COEF_LO, COEF_LO),
                            pack_coef(COEF_LO, COEF_LO, COEF_LO),
                            pack_coord(COORD_LO, COORD_LO, COORD_LO));
      CFG_NOISE: load_regs(random_word(), random_word(), random_word(), random_word(),
                           random_word(), random_word());
      default: load_regs(pack_coord(spread(60000), spread(60000), spread(60000)),
                         pack_coef(spread(2 * UNIT_SCALE), spread(2 * UNIT_SCALE),
                                   spread(2 * UNIT_SCALE)),
                         pack_coef(spread(UNIT_ROT), spread(UNIT_ROT), spread(UNIT_ROT)),
                         pack_coef(spread(UNIT_ROT), spread(UNIT_ROT), spread(UNIT_ROT)),
                         pack_coef(spread(UNIT_ROT), spread(UNIT_ROT), spread(UNIT_ROT)),
                         pack_coord(spread(60000), spread(60000), spread(60000)));
    endcase
  endtask

  task automatic send_point(point_t p);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      pt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_valid <= 1'b1;
    pt       <= p;
    do @(posedge clk); while (!pt_ready);
    chk.take_point(p);
  endtask

  // result side, with one long hold-off so the pipeline backs up to pt_ready
  initial begin
    int stall;
    results_taken = 0;
    hold_done = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        stall = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        stall = $urandom_range(0, take_stall_max);
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      chk.check_result(res);
      results_taken++;
    end
  end

  initial begin
    chk = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers still at reset
    send_point(make_point(KIND_VERTEX, 1000, -1000, 77));
    send_point(make_point(KIND_NORMAL, COORD_HI, COORD_LO, -1));

    // identity rotation with centre and offset, extremes saturate on vertices
    load_regs(pack_coord(256, -512, 0), pack_coef(UNIT_SCALE, UNIT_SCALE, UNIT_SCALE),
              pack_coef(UNIT_ROT, 0, 0), pack_coef(0, UNIT_ROT, 0), pack_coef(0, 0, UNIT_ROT),
              pack_coord(768, 0, -256));
    send_point(make_point(KIND_VERTEX, COORD_HI, COORD_HI, COORD_HI));
    send_point(make_point(KIND_VERTEX, COORD_LO, COORD_LO, COORD_LO));
    send_point(make_point(KIND_VERTEX, 0, 0, 0));
    send_point(make_point(KIND_NORMAL, COORD_HI, COORD_HI, COORD_HI));
    send_point(make_point(KIND_NORMAL, COORD_LO, COORD_LO, COORD_LO));
    send_point(make_point(KIND_NORMAL, 1, -1, 349525));

    // half scale on odd inputs hits rounding ties of both signs
    load_regs('0, pack_coef(UNIT_SCALE / 2, UNIT_SCALE / 2, UNIT_SCALE / 2),
              pack_coef(UNIT_ROT / 2, 0, 0), pack_coef(0, -UNIT_ROT, 0),
              pack_coef(UNIT_ROT, UNIT_ROT, UNIT_ROT), '0);
    send_point(make_point(KIND_NORMAL, 1, -1, 3));
    send_point(make_point(KIND_NORMAL, -3, 5, -5));
    send_point(make_point(KIND_VERTEX, 1, -1, 0));
    send_point(make_point(KIND_VERTEX, -7, 7, -1));

    // largest coefficients, unclamped intermediates
    load_regs(pack_coord(COORD_LO, COORD_HI, 0), pack_coef(COEF_HI, COEF_LO, COEF_HI),
              pack_coef(COEF_HI, COEF_HI, COEF_HI), pack_coef(COEF_LO, COEF_LO, COEF_LO),
              pack_coef(COEF_HI, COEF_LO, 0), pack_coord(COORD_HI, COORD_LO, COORD_HI));
    send_point(make_point(KIND_VERTEX, COORD_HI, COORD_LO, COORD_HI));
    send_point(make_point(KIND_VERTEX, COORD_LO, COORD_HI, COORD_LO));
    send_point(make_point(KIND_NORMAL, COORD_HI, COORD_LO, 0));
    send_point(make_point(KIND_NORMAL, 0, 0, 0));
    send_point(make_point(KIND_VERTEX, COORD_LO, COORD_HI, 0));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_style(phase_plan[ph]);
      send_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 9;
      take_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
      repeat (POINTS_PER_PHASE) send_point(random_point());
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mvat_pkg.sv
hw/rtl/mvat_cfg.sv
hw/rtl/mvat_scale.sv
hw/rtl/mvat_rotate.sv
hw/rtl/mvat_place.sv
hw/rtl/mesh_vertex_affine_transform.sv
dv/mvat_check_pkg.sv
dv/tb_mesh_vertex_affine_transform.sv
